>>> hw/rtl/sbrs_pkg.sv
// ----------------------------------------------------------------------------
// sbrs_pkg
// Shared types and constants for the sparse bit vector rank/select engine.
// ----------------------------------------------------------------------------
package sbrs_pkg;

   localparam int VAL_W   = 13;   // width of indexes, counts and positions
   localparam int KIND_W  = 4;
   localparam int STAT_W  = 2;
   localparam int ROW_W   = 64;   // bits per row of the bit store
   localparam int ROW_LW  = 6;    // log2 of ROW_W

   typedef enum logic [KIND_W-1:0] {
      K_CLEAR_ALL = 4'd0,
      K_SET_ALL   = 4'd1,
      K_SET_BIT   = 4'd2,
      K_CLEAR_BIT = 4'd3,
      K_FINALIZE  = 4'd4,
      K_ACCESS    = 4'd5,
      K_RANK1     = 4'd6,
      K_RANK0     = 4'd7,
      K_SELECT1   = 4'd8,
      K_SELECT0   = 4'd9
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK     = 2'd0,
      ST_REJECT = 2'd1,
      ST_RANGE  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      RS_ZERO  = 3'd0,
      RS_N     = 3'd1,
      RS_HIT   = 3'd2,
      RS_RANK1 = 3'd3,
      RS_RANK0 = 3'd4,
      RS_SEL1  = 3'd5,
      RS_SEL0  = 3'd6
   } rsel_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_FILL,
      S_RMW_RD,
      S_RMW_WR,
      S_FIN_RD,
      S_FIN_BIT,
      S_FIN_END,
      S_SRCH,
      S_SCMP,
      S_HIT,
      S_SEL1,
      S_SEL1D
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic       latch;
      logic       fill_start;
      logic       fill_value;
      logic       fill_step;
      logic       clr_final;
      logic       rmw_rd;
      logic       rmw_wr;
      logic       bit_value;
      logic       fin_start;
      logic       fin_rd;
      logic       fin_bit;
      logic       fin_end;
      logic       srch_start;
      logic       zeros;
      logic       srch_rd;
      logic       srch_cmp;
      logic       last_rd;
      logic       sel1_rd;
      logic       respond;
      rsel_type   rsel;
      status_type rstat;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic finalized;
      logic fill_last;
      logic fin_row_end;
      logic fin_last_bit;
      logic srch_done;
      logic idx_oor;
      logic sel1_none;
      logic sel0_none;
   } stat_type;

endpackage

>>> hw/rtl/sparse_bitvector_rank_select_top.sv
// ----------------------------------------------------------------------------
// sparse_bitvector_rank_select_top
// Rank/select engine over a bit vector with a sorted list of one positions.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears on rsp_value/rsp_status, marked by rsp_strobe, and cannot be
// held off. The controller and the two single-port RAMs set the order:
// set or clear bit reads its row, then writes it back; clear all and set
// all sweep the bit store one 64-bit row a cycle; finalize walks every bit;
// access, rank and select0 binary-search the position list, each search
// step being a position-memory read and a compare; select1 reads the
// position list directly; rejected or out-of-range requests are answered
// from idle. After reset a clearing pass over every row of the bit store
// holds busy high. csr writes are always accepted and are meant for idle
// periods only.
module sparse_bitvector_rank_select_top #(
   parameter int MAX_BITS = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [sbrs_pkg::KIND_W-1:0]   req_kind,
   input  logic [sbrs_pkg::VAL_W-1:0]    req_index,
   output logic                          rsp_strobe,
   output logic [sbrs_pkg::VAL_W-1:0]    rsp_value,
   output logic [sbrs_pkg::STAT_W-1:0]   rsp_status,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sbrs_pkg::VAL_W-1:0]    csr_data
);
   import sbrs_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   sbrs_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_kind (req_kind),
      .stat     (stat),
      .cmd      (cmd)
   );

   sbrs_dpath #(.MAX_BITS(MAX_BITS)) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_index  (req_index),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status)
   );

endmodule

>>> hw/rtl/sbrs_ram.sv
// ----------------------------------------------------------------------------
// sbrs_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module sbrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic [AW-1:0]    addr,
   input  logic             we,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write, and hold read data until the next read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/sbrs_ctrl.sv
// ----------------------------------------------------------------------------
// sbrs_ctrl
// Sequencer for loads, finalize and queries of the rank/select engine.
// ----------------------------------------------------------------------------
module sbrs_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [sbrs_pkg::KIND_W-1:0] req_kind,
   input  sbrs_pkg::stat_type       stat,
   output sbrs_pkg::cmd_type        cmd
);
   import sbrs_pkg::*;

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;

   // state and request kind registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         kind_ff  <= K_CLEAR_ALL;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      cmd      = '0;
      cmd.rsel  = RS_ZERO;
      cmd.rstat = ST_OK;
      cmd.bit_value = (kind_ff == K_SET_BIT);
      cmd.zeros     = (kind_ff == K_SELECT0);
      case (state_ff)
         S_INIT: begin
            cmd.fill_step = 1'b1;
            if (stat.fill_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               kind_in   = kind_type'(req_kind);
               case (kind_type'(req_kind))
                  K_CLEAR_ALL: begin
                     cmd.clr_final  = 1'b1;
                     cmd.fill_start = 1'b1;
                     cmd.fill_value = 1'b0;
                     state_in = S_FILL;
                  end
                  K_SET_ALL, K_SET_BIT, K_CLEAR_BIT, K_FINALIZE: begin
                     if (stat.finalized) begin
                        cmd.respond = 1'b1;
                        cmd.rstat   = ST_REJECT;
                     end else if (kind_type'(req_kind) == K_SET_ALL) begin
                        cmd.fill_start = 1'b1;
                        cmd.fill_value = 1'b1;
                        state_in = S_FILL;
                     end else if (kind_type'(req_kind) == K_FINALIZE) begin
                        cmd.fin_start = 1'b1;
                        state_in = S_FIN_RD;
                     end else if (stat.idx_oor) begin
                        cmd.respond = 1'b1;
                        cmd.rstat   = ST_RANGE;
                     end else begin
                        state_in = S_RMW_RD;
                     end
                  end
                  K_ACCESS, K_RANK1, K_RANK0: begin
                     if (!stat.finalized) begin
                        cmd.respond = 1'b1;
                        cmd.rstat   = ST_REJECT;
                     end else if (stat.idx_oor) begin
                        cmd.respond = 1'b1;
                        cmd.rstat   = ST_RANGE;
                     end else begin
                        cmd.srch_start = 1'b1;
                        state_in = S_SRCH;
                     end
                  end
                  K_SELECT1: begin
                     if (!stat.finalized) begin
                        cmd.respond = 1'b1;
                        cmd.rstat   = ST_REJECT;
                     end else if (stat.sel1_none) begin
                        cmd.respond = 1'b1;
                        cmd.rsel    = RS_N;
                     end else begin
                        state_in = S_SEL1;
                     end
                  end
                  K_SELECT0: begin
                     if (!stat.finalized) begin
                        cmd.respond = 1'b1;
                        cmd.rstat   = ST_REJECT;
                     end else if (stat.sel0_none) begin
                        cmd.respond = 1'b1;
                        cmd.rsel    = RS_N;
                     end else begin
                        cmd.srch_start = 1'b1;
                        state_in = S_SRCH;
                     end
                  end
                  default: begin
                     cmd.respond = 1'b1;
                     cmd.rstat   = ST_REJECT;
                  end
               endcase
            end
         end
         S_FILL: begin
            cmd.fill_step = 1'b1;
            if (stat.fill_last) begin
               cmd.respond = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_RMW_RD: begin
            cmd.rmw_rd = 1'b1;
            state_in = S_RMW_WR;
         end
         S_RMW_WR: begin
            cmd.rmw_wr  = 1'b1;
            cmd.respond = 1'b1;
            state_in = S_IDLE;
         end
         S_FIN_RD: begin
            cmd.fin_rd = 1'b1;
            state_in = S_FIN_BIT;
         end
         S_FIN_BIT: begin
            cmd.fin_bit = 1'b1;
            if (stat.fin_last_bit) begin
               state_in = S_FIN_END;
            end else if (stat.fin_row_end) begin
               state_in = S_FIN_RD;
            end
         end
         S_FIN_END: begin
            cmd.fin_end = 1'b1;
            cmd.respond = 1'b1;
            state_in = S_IDLE;
         end
         S_SRCH: begin
            if (!stat.srch_done) begin
               cmd.srch_rd = 1'b1;
               state_in = S_SCMP;
            end else if (kind_ff == K_SELECT0) begin
               cmd.respond = 1'b1;
               cmd.rsel    = RS_SEL0;
               state_in = S_IDLE;
            end else begin
               cmd.last_rd = 1'b1;
               state_in = S_HIT;
            end
         end
         S_SCMP: begin
            cmd.srch_cmp = 1'b1;
            state_in = S_SRCH;
         end
         S_HIT: begin
            cmd.respond = 1'b1;
            case (kind_ff)
               K_ACCESS: cmd.rsel = RS_HIT;
               K_RANK1:  cmd.rsel = RS_RANK1;
               default:  cmd.rsel = RS_RANK0;
            endcase
            state_in = S_IDLE;
         end
         S_SEL1: begin
            cmd.sel1_rd = 1'b1;
            state_in = S_SEL1D;
         end
         S_SEL1D: begin
            cmd.respond = 1'b1;
            cmd.rsel    = RS_SEL1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

>>> hw/rtl/sbrs_dpath.sv
// ----------------------------------------------------------------------------
// sbrs_dpath
// Bit store, one-position list, search registers and result register.
// ----------------------------------------------------------------------------
module sbrs_dpath #(
   parameter int MAX_BITS = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [sbrs_pkg::VAL_W-1:0]  req_index,
   input  logic                        csr_valid,
   input  logic [sbrs_pkg::VAL_W-1:0]  csr_data,
   input  sbrs_pkg::cmd_type           cmd,
   output sbrs_pkg::stat_type          stat,
   output logic                        rsp_strobe,
   output logic [sbrs_pkg::VAL_W-1:0]  rsp_value,
   output logic [sbrs_pkg::STAT_W-1:0] rsp_status
);
   import sbrs_pkg::*;

   localparam int ROWS   = (MAX_BITS + ROW_W - 1) / ROW_W;
   localparam int RAW    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int PDEPTH = MAX_BITS + 1;
   localparam int PAW    = $clog2(PDEPTH);

   logic [VAL_W-1:0]  bit_count_ff;
   logic              finalized_ff;
   logic [VAL_W-1:0]  ones_total_ff;
   logic [VAL_W-1:0]  index_ff;
   logic [VAL_W-1:0]  lo_ff, hi_ff;
   logic [VAL_W-1:0]  ptr_ff, cnt_ff;
   logic [RAW-1:0]    row_ff;
   logic              fill_ff;
   logic              rsp_strobe_ff;
   logic [VAL_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [STAT_W-1:0] rsp_status_ff;

   logic [VAL_W-1:0]  n_used;
   logic [VAL_W:0]    mid_sum;
   logic [VAL_W-1:0]  mid, key, r1, zeros;
   logic              hit, cur_bit;

   logic [RAW-1:0]    baddr;
   logic              bwe, bre;
   logic [ROW_W-1:0]  bwdata, brdata, rmw_row;
   logic [PAW-1:0]    paddr;
   logic              pwe, pre;
   logic [VAL_W-1:0]  pwdata, prdata;

   // clamp the configured size to 1..MAX_BITS
   always_comb begin
      if (bit_count_ff == '0) begin
         n_used = VAL_W'(1);
      end else if (32'(bit_count_ff) > 32'(MAX_BITS)) begin
         n_used = VAL_W'(MAX_BITS);
      end else begin
         n_used = bit_count_ff;
      end
   end

   // search helpers
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[VAL_W:1];
   assign key     = cmd.zeros ? (prdata - mid) : prdata;
   assign hit     = (prdata == index_ff);
   assign r1      = lo_ff + {{(VAL_W-1){1'b0}}, hit};
   assign zeros   = n_used - ones_total_ff;
   assign cur_bit = brdata[ptr_ff[ROW_LW-1:0]];

   // status toward the controller
   always_comb begin
      stat.finalized    = finalized_ff;
      stat.fill_last    = (row_ff == RAW'(ROWS - 1));
      stat.fin_row_end  = (ptr_ff[ROW_LW-1:0] == {ROW_LW{1'b1}});
      stat.fin_last_bit = (ptr_ff == n_used - VAL_W'(1));
      stat.srch_done    = (lo_ff >= hi_ff);
      stat.idx_oor      = (req_index >= n_used);
      stat.sel1_none    = (req_index == '0) || (req_index > ones_total_ff);
      stat.sel0_none    = (req_index == '0) || (req_index > zeros);
   end

   // bit store port
   always_comb begin
      rmw_row = brdata;
      rmw_row[index_ff[ROW_LW-1:0]] = cmd.bit_value;
      bwe = cmd.fill_step || cmd.rmw_wr;
      bre = cmd.rmw_rd || cmd.fin_rd;
      bwdata = cmd.fill_step ? {ROW_W{fill_ff}} : rmw_row;
      if (cmd.fill_step) begin
         baddr = row_ff;
      end else if (cmd.fin_rd) begin
         baddr = RAW'(ptr_ff >> ROW_LW);
      end else begin
         baddr = RAW'(index_ff >> ROW_LW);
      end
   end

   // position list port
   always_comb begin
      pwe    = (cmd.fin_bit && cur_bit) || cmd.fin_end;
      pre    = cmd.srch_rd || cmd.last_rd || cmd.sel1_rd;
      pwdata = cmd.fin_end ? n_used : ptr_ff;
      if (cmd.srch_rd) begin
         paddr = PAW'(mid);
      end else if (cmd.last_rd) begin
         paddr = PAW'(lo_ff);
      end else if (cmd.sel1_rd) begin
         paddr = PAW'(index_ff - VAL_W'(1));
      end else begin
         paddr = PAW'(cnt_ff);
      end
   end

   sbrs_ram #(.WIDTH(ROW_W), .DEPTH(ROWS), .AW(RAW)) u_bits (
      .clock (clock),
      .addr  (baddr),
      .we    (bwe),
      .wdata (bwdata),
      .re    (bre),
      .rdata (brdata)
   );

   sbrs_ram #(.WIDTH(VAL_W), .DEPTH(PDEPTH), .AW(PAW)) u_pos (
      .clock (clock),
      .addr  (paddr),
      .we    (pwe),
      .wdata (pwdata),
      .re    (pre),
      .rdata (prdata)
   );

   // select the result value
   always_comb begin
      case (cmd.rsel)
         RS_ZERO:  rsp_value_in = '0;
         RS_N:     rsp_value_in = n_used;
         RS_HIT:   rsp_value_in = {{(VAL_W-1){1'b0}}, hit};
         RS_RANK1: rsp_value_in = r1;
         RS_RANK0: rsp_value_in = index_ff + VAL_W'(1) - r1;
         RS_SEL1:  rsp_value_in = prdata;
         RS_SEL0:  rsp_value_in = lo_ff + index_ff - VAL_W'(1);
         default:  rsp_value_in = '0;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_count_ff  <= VAL_W'(4096);
         finalized_ff  <= 1'b0;
         ones_total_ff <= '0;
         row_ff        <= '0;
         fill_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.respond;
         if (csr_valid) begin
            bit_count_ff <= csr_data;
         end
         if (csr_valid || cmd.clr_final) begin
            finalized_ff <= 1'b0;
         end else if (cmd.fin_end) begin
            finalized_ff <= 1'b1;
         end
         if (cmd.fin_end) begin
            ones_total_ff <= cnt_ff;
         end
         if (cmd.fill_start) begin
            row_ff  <= '0;
            fill_ff <= cmd.fill_value;
         end else if (cmd.fill_step) begin
            row_ff <= row_ff + RAW'(1);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         index_ff <= req_index;
      end
      if (cmd.fin_start) begin
         ptr_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.fin_bit) begin
         ptr_ff <= ptr_ff + VAL_W'(1);
         if (cur_bit) begin
            cnt_ff <= cnt_ff + VAL_W'(1);
         end
      end
      if (cmd.srch_start) begin
         lo_ff <= '0;
         hi_ff <= ones_total_ff;
      end else if (cmd.srch_cmp) begin
         if (index_ff > key) begin
            lo_ff <= mid + VAL_W'(1);
         end else begin
            hi_ff <= mid;
         end
      end
      if (cmd.respond) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= cmd.rstat;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule
